// ===== rtl/spf_pkg.sv =====
package spf_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int CMD_W    = 2;
    localparam int VTX_W    = 6;
    localparam int NV_W     = 7;
    localparam int WPORT_W  = 16;
    localparam int NV_RESET = 64;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INIT     = 11'b000_0000_0010,
        S_SCAN     = 11'b000_0000_0100,
        S_PICK     = 11'b000_0000_1000,
        S_RELAX    = 11'b000_0001_0000,
        S_WALK_RD  = 11'b000_0010_0000,
        S_WALK_WT  = 11'b000_0100_0000,
        S_EMIT_RD  = 11'b000_1000_0000,
        S_EMIT_OUT = 11'b001_0000_0000,
        S_MISS     = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

endpackage

// ===== rtl/spf_ram.sv =====
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/shortest_path_finder.sv =====
// Single-source shortest path engine. Load edges with command 1 (command 0
// empties the table), then issue command 2 with a source and a destination;
// the block answers with the path from source to destination, one vertex per
// result on o_valid, o_last marking the final one, or a single result with
// o_found low when the destination cannot be reached or an index is at or
// above the vertex count. Results are strobed for exactly one cycle and the
// receiver cannot stall them; start is taken only while busy is low. Clear
// and add do not raise busy. A query with a bad index goes straight to the
// miss result. Any other query first makes a pass over the distance memory
// that clears the reached and visited marks. Each round then scans the
// distance memory once through its single read port for the closest open
// vertex, marks it visited and streams every edge through a three-stage
// read/read/update pipeline against the same memory. The parent chain is
// walked through a read state and a wait state per vertex, and the path is
// emitted through a read state and an output state per vertex. num_vertices
// may be written through the config channel only while idle.
module shortest_path_finder #(
    parameter int MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = spf_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = spf_pkg::WEIGHT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [spf_pkg::CMD_W-1:0]  i_command,
    input  logic [spf_pkg::VTX_W-1:0]  i_owner_vertex,
    input  logic [spf_pkg::VTX_W-1:0]  i_end_a,
    input  logic [spf_pkg::VTX_W-1:0]  i_end_b,
    input  logic [spf_pkg::WPORT_W-1:0] i_edge_weight,
    input  logic [spf_pkg::VTX_W-1:0]  i_source_vertex,
    input  logic [spf_pkg::VTX_W-1:0]  i_dest_vertex,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [spf_pkg::NV_W-1:0]   i_cfg_num_vertices,
    output logic                       o_valid,
    output logic [spf_pkg::VTX_W-1:0]  o_path_vertex,
    output logic                       o_found,
    output logic                       o_last
);

    localparam int VI  = $clog2(MAX_VERTICES);
    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int W   = WEIGHT_BITS;
    localparam int DW  = WEIGHT_BITS + VI;
    // distance word: {reached, visited, distance}
    localparam int DMW = DW + 2;
    localparam int V6  = spf_pkg::VTX_W;
    localparam int NVW = spf_pkg::NV_W;
    localparam int EW  = 3 * V6 + W;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    spf_pkg::t_state r_state, n_state;

    logic [NVW-1:0]  r_nv_reg;
    logic [ECW-1:0]  r_edge_cnt, n_edge_cnt;
    logic [VI-1:0]   r_src, n_src;
    logic [VI-1:0]   r_dst, n_dst;
    logic            r_dst_hit, n_dst_hit;

    // clear pass and scan for the closest open vertex
    logic [NVW-1:0]  r_scan_idx, n_scan_idx;
    logic            r_scan_pend, n_scan_pend;
    logic [VI-1:0]   r_scan_j, n_scan_j;
    logic            r_have_best, n_have_best;
    logic [VI-1:0]   r_best, n_best;
    logic [DW-1:0]   r_best_d, n_best_d;

    // relax pipeline
    logic [ECW-1:0]  r_eidx, n_eidx;
    logic            r_a_v, n_a_v;
    logic            r_b_v, n_b_v;
    logic [VI-1:0]   r_b_to, n_b_to;
    logic [DW-1:0]   r_b_nd, n_b_nd;
    logic            r_fw_v, n_fw_v;
    logic [VI-1:0]   r_fw_addr, n_fw_addr;
    logic [DMW-1:0]  r_fw_d, n_fw_d;

    // path walk and emit
    logic [VI-1:0]   r_cur, n_cur;
    logic [VW-1:0]   r_len, n_len;
    logic [VI-1:0]   r_eix, n_eix;

    logic            r_valid, n_valid;
    logic [V6-1:0]   r_pv, n_pv;
    logic            r_found, n_found;
    logic            r_last, n_last;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic            edge_we;
    logic [EA-1:0]   edge_waddr, edge_raddr;
    logic [EW-1:0]   edge_wdata, edge_rdata;

    logic            dist_we;
    logic [VI-1:0]   dist_waddr, dist_raddr;
    logic [DMW-1:0]  dist_wdata, dist_rdata;

    logic            par_we;
    logic [VI-1:0]   par_waddr, par_raddr;
    logic [VI-1:0]   par_wdata, par_rdata;

    logic            stk_we;
    logic [VI-1:0]   stk_waddr, stk_raddr;
    logic [VI-1:0]   stk_wdata, stk_rdata;

    spf_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    spf_ram #(.WIDTH(DMW), .DEPTH(MAX_VERTICES)) u_dist_ram (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_waddr), .i_wdata(dist_wdata),
        .i_raddr(dist_raddr), .o_rdata(dist_rdata)
    );

    spf_ram #(.WIDTH(VI), .DEPTH(MAX_VERTICES)) u_parent_ram (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_rdata)
    );

    spf_ram #(.WIDTH(VI), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    logic [NVW-1:0] nv;
    logic [31:0]    w_ext;
    logic [W-1:0]   w_in;
    logic           accept;

    // clamp the vertex count to what the memories hold
    assign nv     = (r_nv_reg > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : r_nv_reg;
    assign w_ext  = {16'b0, i_edge_weight};
    assign w_in   = w_ext[W-1:0];
    assign accept = start && !busy;

    assign busy        = (r_state != spf_pkg::S_IDLE);
    assign o_cfg_ready = !busy;

    // edge fields as read back
    logic [V6-1:0] e_owner, e_a, e_b, e_to;
    logic [W-1:0]  e_w;
    logic          e_hit;
    assign e_owner = edge_rdata[EW-1 -: V6];
    assign e_a     = edge_rdata[EW-1-V6 -: V6];
    assign e_b     = edge_rdata[EW-1-2*V6 -: V6];
    assign e_w     = edge_rdata[W-1:0];
    assign e_to    = (e_a == V6'(r_best)) ? e_b : e_a;
    assign e_hit   = r_a_v && (e_owner == V6'(r_best)) && ({1'b0, e_to} < nv);

    // distance word as scanned
    logic          s_reached, s_visited;
    logic [DW-1:0] s_dist;
    assign s_reached = dist_rdata[DMW-1];
    assign s_visited = dist_rdata[DW];
    assign s_dist    = dist_rdata[DW-1:0];

    // current word of the relax target, forwarded from last cycle's write
    logic [DMW-1:0] c_word;
    logic           c_upd;
    assign c_word = (r_fw_v && (r_fw_addr == r_b_to)) ? r_fw_d : dist_rdata;
    assign c_upd  = r_b_v && (!c_word[DMW-1] || (c_word[DW-1:0] > r_b_nd));

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_edge_cnt  = r_edge_cnt;
        n_src       = r_src;
        n_dst       = r_dst;
        n_dst_hit   = r_dst_hit;
        n_scan_idx  = r_scan_idx;
        n_scan_pend = 1'b0;
        n_scan_j    = r_scan_j;
        n_have_best = r_have_best;
        n_best      = r_best;
        n_best_d    = r_best_d;
        n_eidx      = r_eidx;
        n_a_v       = 1'b0;
        n_b_v       = 1'b0;
        n_b_to      = r_b_to;
        n_b_nd      = r_b_nd;
        n_fw_v      = 1'b0;
        n_fw_addr   = r_fw_addr;
        n_fw_d      = r_fw_d;
        n_cur       = r_cur;
        n_len       = r_len;
        n_eix       = r_eix;
        n_valid     = 1'b0;
        n_pv        = r_pv;
        n_found     = r_found;
        n_last      = r_last;

        edge_we    = 1'b0;
        edge_waddr = r_edge_cnt[EA-1:0];
        edge_wdata = {i_owner_vertex, i_end_a, i_end_b, w_in};
        edge_raddr = r_eidx[EA-1:0];

        dist_we    = 1'b0;
        dist_waddr = r_b_to;
        dist_wdata = {1'b1, c_word[DW], r_b_nd};
        dist_raddr = r_scan_idx[VI-1:0];

        par_we     = 1'b0;
        par_waddr  = r_b_to;
        par_wdata  = r_best;
        par_raddr  = r_cur;

        stk_we     = 1'b0;
        stk_waddr  = r_len[VI-1:0];
        stk_wdata  = r_cur;
        stk_raddr  = r_eix;

        unique case (r_state)
            spf_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        spf_pkg::CMD_CLEAR: n_edge_cnt = '0;
                        spf_pkg::CMD_ADD: begin
                            // drop edges past capacity
                            if (r_edge_cnt < ECW'(MAX_EDGES)) begin
                                edge_we    = 1'b1;
                                n_edge_cnt = r_edge_cnt + 1'b1;
                            end
                        end
                        spf_pkg::CMD_QUERY: begin
                            n_src = i_source_vertex[VI-1:0];
                            n_dst = i_dest_vertex[VI-1:0];
                            if (({1'b0, i_source_vertex} >= nv) ||
                                ({1'b0, i_dest_vertex} >= nv)) begin
                                n_state = spf_pkg::S_MISS;
                            end else begin
                                n_dst_hit  = (i_source_vertex == i_dest_vertex);
                                n_scan_idx = '0;
                                n_state    = spf_pkg::S_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            spf_pkg::S_INIT: begin
                // clear every mark; seed the source: reached, distance zero,
                // its own parent
                par_we    = 1'b1;
                par_waddr = r_src;
                par_wdata = r_src;
                if (r_scan_idx < nv) begin
                    dist_we    = 1'b1;
                    dist_waddr = r_scan_idx[VI-1:0];
                    dist_wdata = (r_scan_idx[VI-1:0] == r_src) ?
                                 {1'b1, {(DMW-1){1'b0}}} : '0;
                    n_scan_idx = r_scan_idx + 1'b1;
                end else begin
                    n_scan_idx  = '0;
                    n_have_best = 1'b0;
                    n_state     = spf_pkg::S_SCAN;
                end
            end

            spf_pkg::S_SCAN: begin
                if (r_scan_idx < nv) begin
                    dist_raddr  = r_scan_idx[VI-1:0];
                    n_scan_pend = 1'b1;
                    n_scan_j    = r_scan_idx[VI-1:0];
                    n_scan_idx  = r_scan_idx + 1'b1;
                end
                // strict less keeps the lower index on ties
                if (r_scan_pend && s_reached && !s_visited &&
                    (!r_have_best || (s_dist < r_best_d))) begin
                    n_have_best = 1'b1;
                    n_best      = r_scan_j;
                    n_best_d    = s_dist;
                end
                if ((r_scan_idx >= nv) && !r_scan_pend) begin
                    n_state = spf_pkg::S_PICK;
                end
            end

            spf_pkg::S_PICK: begin
                if (r_have_best) begin
                    // mark the chosen vertex visited
                    dist_we    = 1'b1;
                    dist_waddr = r_best;
                    dist_wdata = {2'b11, r_best_d};
                    n_eidx     = '0;
                    n_state    = spf_pkg::S_RELAX;
                end else if (r_dst_hit) begin
                    n_cur   = r_dst;
                    n_len   = '0;
                    n_state = spf_pkg::S_WALK_RD;
                end else begin
                    n_state = spf_pkg::S_MISS;
                end
            end

            spf_pkg::S_RELAX: begin
                // stage A: fetch edge
                if (r_eidx < r_edge_cnt) begin
                    edge_raddr = r_eidx[EA-1:0];
                    n_a_v      = 1'b1;
                    n_eidx     = r_eidx + 1'b1;
                end
                // stage B: resolve neighbor, fetch its distance word
                dist_raddr = e_to[VI-1:0];
                n_b_v      = e_hit;
                n_b_to     = e_to[VI-1:0];
                n_b_nd     = r_best_d + DW'(e_w);
                // stage C: update on strict improvement, keep the visited mark
                if (c_upd) begin
                    dist_we   = 1'b1;
                    par_we    = 1'b1;
                    n_fw_v    = 1'b1;
                    n_fw_addr = r_b_to;
                    n_fw_d    = {1'b1, c_word[DW], r_b_nd};
                    if (r_b_to == r_dst) begin
                        n_dst_hit = 1'b1;
                    end
                end
                if ((r_eidx >= r_edge_cnt) && !r_a_v && !r_b_v) begin
                    n_scan_idx  = '0;
                    n_have_best = 1'b0;
                    n_state     = spf_pkg::S_SCAN;
                end
            end

            spf_pkg::S_WALK_RD: begin
                // push current vertex, fetch its parent
                stk_we    = 1'b1;
                stk_waddr = r_len[VI-1:0];
                stk_wdata = r_cur;
                par_raddr = r_cur;
                n_len     = r_len + 1'b1;
                n_state   = spf_pkg::S_WALK_WT;
            end

            spf_pkg::S_WALK_WT: begin
                if ((par_rdata == r_cur) || (r_len == VW'(MAX_VERTICES))) begin
                    n_eix   = VI'(r_len - 1'b1);
                    n_state = spf_pkg::S_EMIT_RD;
                end else begin
                    n_cur   = par_rdata;
                    n_state = spf_pkg::S_WALK_RD;
                end
            end

            spf_pkg::S_EMIT_RD: begin
                stk_raddr = r_eix;
                n_state   = spf_pkg::S_EMIT_OUT;
            end

            spf_pkg::S_EMIT_OUT: begin
                n_valid = 1'b1;
                n_pv    = V6'(stk_rdata);
                n_found = 1'b1;
                n_last  = (r_eix == '0);
                if (r_eix == '0) begin
                    n_state = spf_pkg::S_DONE;
                end else begin
                    n_eix   = r_eix - 1'b1;
                    n_state = spf_pkg::S_EMIT_RD;
                end
            end

            spf_pkg::S_MISS: begin
                n_valid = 1'b1;
                n_pv    = '0;
                n_found = 1'b0;
                n_last  = 1'b1;
                n_state = spf_pkg::S_DONE;
            end

            spf_pkg::S_DONE: n_state = spf_pkg::S_IDLE;

            default: n_state = spf_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spf_pkg::S_IDLE;
            r_nv_reg    <= NVW'(spf_pkg::NV_RESET);
            r_edge_cnt  <= '0;
            r_dst_hit   <= 1'b0;
            r_scan_idx  <= '0;
            r_scan_pend <= 1'b0;
            r_have_best <= 1'b0;
            r_eidx      <= '0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_fw_v      <= 1'b0;
            r_len       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_nv_reg <= i_cfg_num_vertices;
            end
            r_edge_cnt  <= n_edge_cnt;
            r_dst_hit   <= n_dst_hit;
            r_scan_idx  <= n_scan_idx;
            r_scan_pend <= n_scan_pend;
            r_have_best <= n_have_best;
            r_eidx      <= n_eidx;
            r_a_v       <= n_a_v;
            r_b_v       <= n_b_v;
            r_fw_v      <= n_fw_v;
            r_len       <= n_len;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_scan_j  <= n_scan_j;
        r_best    <= n_best;
        r_best_d  <= n_best_d;
        r_b_to    <= n_b_to;
        r_b_nd    <= n_b_nd;
        r_fw_addr <= n_fw_addr;
        r_fw_d    <= n_fw_d;
        r_cur     <= n_cur;
        r_eix     <= n_eix;
        r_pv      <= n_pv;
        r_found   <= n_found;
        r_last    <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_path_vertex = r_pv;
    assign o_found       = r_found;
    assign o_last        = r_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("result without last flag while engine idle");

    a_relax_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spf_pkg::S_RELAX) |-> r_have_best)
        else $error("relaxing edges without a chosen vertex");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= VW'(MAX_VERTICES))
        else $error("path stack overflow");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == spf_pkg::CMD_QUERY)) |=> !o_valid)
        else $error("result issued in the cycle after a query was taken");

    a_relax_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_upd |-> ({1'b0, V6'(r_b_to)} < nv))
        else $error("relax target outside vertex range");

endmodule
